FILE: hw/rtl/edps_pkg.sv
// ----------------------------------------------------------------------------
// Epoch difference package
// Field widths, codes and word types shared by the epoch difference block.
// ----------------------------------------------------------------------------
package edps_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int MAX_TYPES   = 8;
  localparam int SAT_ID_W    = 6;
  localparam int ARC_W       = 16;
  localparam int MASK_W      = 8;

  // Observation type slots, in word order.
  localparam int TYPE_CODE_PREFIT  = 0;
  localparam int TYPE_PHASE_PREFIT = 1;
  localparam int TYPE_WET_MAP      = 2;
  localparam int TYPE_C1_PREFIT    = 3;
  localparam int TYPE_P1_PREFIT    = 4;
  localparam int TYPE_P2_PREFIT    = 5;
  localparam int TYPE_L1_PREFIT    = 6;
  localparam int TYPE_L2_PREFIT    = 7;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [SAT_ID_W-1:0] sat_id;
    logic [ARC_W-1:0]    arc_number;
    logic [MASK_W-1:0]   present_mask;
    value_t              value_code_prefit;
    value_t              value_phase_prefit;
    value_t              value_wet_map;
    value_t              value_c1_prefit;
    value_t              value_p1_prefit;
    value_t              value_p2_prefit;
    value_t              value_l1_prefit;
    value_t              value_l2_prefit;
    logic                epoch_end;
  } obs_word_t;

  typedef struct packed {
    logic [SAT_ID_W-1:0] out_sat_id;
    logic                keep;
    value_t              diff_code_prefit;
    value_t              diff_phase_prefit;
    value_t              diff_wet_map;
    value_t              diff_c1_prefit;
    value_t              diff_p1_prefit;
    value_t              diff_p2_prefit;
    value_t              diff_l1_prefit;
    value_t              diff_l2_prefit;
    logic                out_epoch_end;
  } diff_word_t;

endpackage

FILE: hw/rtl/edps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module edps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/edps_sat_sub.sv
// ----------------------------------------------------------------------------
// Saturating difference lane
// Current minus previous value, clamped to the signed value range, or zero.
// ----------------------------------------------------------------------------
module edps_sat_sub (
  input  edps_pkg::value_t cur,
  input  edps_pkg::value_t prev,
  input  logic             en,
  output edps_pkg::value_t diff
);
  import edps_pkg::*;

  localparam value_t MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH:0] wide;

  assign wide = {cur[VALUE_WIDTH-1], cur} - {prev[VALUE_WIDTH-1], prev};

  always_comb begin
    if (!en) begin
      diff = '0;
    end else if (wide[VALUE_WIDTH] != wide[VALUE_WIDTH-1]) begin
      // The sign of the extended result tells which way it ran over.
      diff = wide[VALUE_WIDTH] ? MIN_VAL : MAX_VAL;
    end else begin
      diff = wide[VALUE_WIDTH-1:0];
    end
  end

endmodule

FILE: hw/rtl/epoch_difference_per_satellite.sv
// ----------------------------------------------------------------------------
// Between-epoch difference per satellite
// Differences each satellite record against the last record of that satellite.
//
//   channel  direction  handshake              payload
//   obs      in         obs_valid / obs_ready  obs_word  (obs_word_t)
//   diff     out        diff_valid/ diff_ready diff_word (diff_word_t)
//   cfg      in         cfg_we                 cfg_data  (type mask)
//
// diff_valid rises when the word moves from the s1 register to the output
// register; one word per cycle is accepted while the output keeps draining.
// The record RAM is read on acceptance and written when the word moves to the
// output register; a back-to-back record of the same satellite takes the
// forwarded record.
// Reset clears the seen masks, the type mask and the valid flags; the RAM
// needs no clearing. A stalled output holds the pipeline.
// ----------------------------------------------------------------------------
module epoch_difference_per_satellite #(
  parameter int NUM_SATS  = 64,
  parameter int NUM_TYPES = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    obs_valid,
  output logic                    obs_ready,
  input  edps_pkg::obs_word_t     obs_word,
  output logic                    diff_valid,
  input  logic                    diff_ready,
  output edps_pkg::diff_word_t    diff_word,
  input  logic                    cfg_we,
  input  logic [edps_pkg::MASK_W-1:0] cfg_data
);
  import edps_pkg::*;

  localparam int IDX_W   = $clog2(NUM_SATS);
  localparam int PRES_LO = ARC_W;
  localparam int VAL_LO  = ARC_W + MASK_W;
  localparam int REC_W   = VAL_LO + NUM_TYPES * VALUE_WIDTH;
  localparam logic [MASK_W-1:0] TYPE_EN =
    MASK_W'((9'd1 << NUM_TYPES) - 9'd1);

  logic [MASK_W-1:0]   type_mask;
  logic                s1_valid;
  obs_word_t           s1_word;
  logic                s1_fwd;
  logic [REC_W-1:0]    fwd_rec;
  logic [NUM_SATS-1:0] seen_last;
  logic [NUM_SATS-1:0] seen_this;
  logic [NUM_SATS-1:0] seen_this_set;

  logic                acc;
  logic                s1_adv;
  logic [IDX_W-1:0]    obs_idx;
  logic [IDX_W-1:0]    s1_idx;
  logic                s1_in_range;
  logic                ram_we;
  logic [REC_W-1:0]    wr_rec;
  logic [REC_W-1:0]    rd_rec;
  logic [REC_W-1:0]    prev_rec;
  logic [MASK_W-1:0]   sel;
  logic                keep;
  value_t              cur_val [MAX_TYPES];
  value_t              diff_val [MAX_TYPES];
  diff_word_t          diff_word_next;

  assign acc     = obs_valid && obs_ready;
  assign s1_adv  = s1_valid && (!diff_valid || diff_ready);
  assign obs_ready = !s1_valid || s1_adv;

  assign obs_idx     = IDX_W'(obs_word.sat_id);
  assign s1_idx      = IDX_W'(s1_word.sat_id);
  assign s1_in_range = 32'(s1_word.sat_id) < NUM_SATS;
  assign ram_we      = s1_adv && s1_in_range;

  always_comb begin
    cur_val[TYPE_CODE_PREFIT]  = s1_word.value_code_prefit;
    cur_val[TYPE_PHASE_PREFIT] = s1_word.value_phase_prefit;
    cur_val[TYPE_WET_MAP]      = s1_word.value_wet_map;
    cur_val[TYPE_C1_PREFIT]    = s1_word.value_c1_prefit;
    cur_val[TYPE_P1_PREFIT]    = s1_word.value_p1_prefit;
    cur_val[TYPE_P2_PREFIT]    = s1_word.value_p2_prefit;
    cur_val[TYPE_L1_PREFIT]    = s1_word.value_l1_prefit;
    cur_val[TYPE_L2_PREFIT]    = s1_word.value_l2_prefit;
  end

  always_comb begin
    wr_rec = '0;
    wr_rec[ARC_W-1:0]            = s1_word.arc_number;
    wr_rec[PRES_LO +: MASK_W]    = s1_word.present_mask;
    for (int t = 0; t < NUM_TYPES; t++) begin
      wr_rec[VAL_LO + t*VALUE_WIDTH +: VALUE_WIDTH] = cur_val[t];
    end
  end

  edps_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SATS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (wr_rec),
    .re    (acc),
    .raddr (obs_idx),
    .rdata (rd_rec)
  );

  // The record written in the cycle of a read is not yet in the RAM output.
  assign prev_rec = s1_fwd ? fwd_rec : rd_rec;
  assign sel      = type_mask & TYPE_EN;

  assign keep = s1_in_range && seen_last[s1_idx] &&
                (prev_rec[ARC_W-1:0] == s1_word.arc_number) &&
                ((sel & s1_word.present_mask & prev_rec[PRES_LO +: MASK_W]) == sel);

  for (genvar t = 0; t < MAX_TYPES; t++) begin : g_lane
    if (t < NUM_TYPES) begin : g_used
      edps_sat_sub u_sub (
        .cur  (cur_val[t]),
        .prev (prev_rec[VAL_LO + t*VALUE_WIDTH +: VALUE_WIDTH]),
        .en   (keep && sel[t]),
        .diff (diff_val[t])
      );
    end else begin : g_unused
      assign diff_val[t] = '0;
    end
  end

  always_comb begin
    diff_word_next.out_sat_id        = s1_word.sat_id;
    diff_word_next.keep              = keep;
    diff_word_next.diff_code_prefit  = diff_val[TYPE_CODE_PREFIT];
    diff_word_next.diff_phase_prefit = diff_val[TYPE_PHASE_PREFIT];
    diff_word_next.diff_wet_map      = diff_val[TYPE_WET_MAP];
    diff_word_next.diff_c1_prefit    = diff_val[TYPE_C1_PREFIT];
    diff_word_next.diff_p1_prefit    = diff_val[TYPE_P1_PREFIT];
    diff_word_next.diff_p2_prefit    = diff_val[TYPE_P2_PREFIT];
    diff_word_next.diff_l1_prefit    = diff_val[TYPE_L1_PREFIT];
    diff_word_next.diff_l2_prefit    = diff_val[TYPE_L2_PREFIT];
    diff_word_next.out_epoch_end     = s1_word.epoch_end;
  end

  always_comb begin
    for (int i = 0; i < NUM_SATS; i++) begin
      seen_this_set[i] = seen_this[i] || (s1_in_range && (s1_idx == IDX_W'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask  <= '0;
      s1_valid   <= 1'b0;
      diff_valid <= 1'b0;
      seen_last  <= '0;
      seen_this  <= '0;
    end else begin
      if (cfg_we) begin
        type_mask <= cfg_data;
      end
      if (obs_ready) begin
        s1_valid <= obs_valid;
      end
      if (!diff_valid || diff_ready) begin
        diff_valid <= s1_valid;
      end
      if (s1_adv) begin
        if (s1_word.epoch_end) begin
          seen_last <= seen_this_set;
          seen_this <= '0;
        end else begin
          seen_this <= seen_this_set;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_word <= obs_word;
      s1_fwd  <= ram_we && (s1_idx == obs_idx);
      fwd_rec <= wr_rec;
    end
    if (s1_adv) begin
      diff_word <= diff_word_next;
    end
  end

endmodule

FILE: hw/rtl/edps_checker.sv
// ----------------------------------------------------------------------------
// Epoch difference checker
// Port-level properties of the epoch difference block, bound to the top.
// ----------------------------------------------------------------------------
module edps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        obs_valid,
  input logic                        obs_ready,
  input edps_pkg::obs_word_t         obs_word,
  input logic                        diff_valid,
  input logic                        diff_ready,
  input edps_pkg::diff_word_t        diff_word
);
  import edps_pkg::*;

  logic [1:0] pending;
  logic       obs_acc;
  logic       diff_acc;

  assign obs_acc  = obs_valid && obs_ready;
  assign diff_acc = diff_valid && diff_ready;

  // Words accepted but not yet delivered; the pipeline holds at most two.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (obs_acc && !diff_acc) begin
      pending <= pending + 2'd1;
    end else if (diff_acc && !obs_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !diff_valid)
    else $error("diff_valid high after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    diff_valid && !diff_word.keep |->
      diff_word.diff_code_prefit == '0 && diff_word.diff_phase_prefit == '0 &&
      diff_word.diff_wet_map == '0 && diff_word.diff_c1_prefit == '0 &&
      diff_word.diff_p1_prefit == '0 && diff_word.diff_p2_prefit == '0 &&
      diff_word.diff_l1_prefit == '0 && diff_word.diff_l2_prefit == '0)
    else $error("rejected word carries a nonzero difference");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    diff_valid |-> pending != 2'd0 && pending != 2'd3)
    else $error("output word without a matching input word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    diff_valid && !diff_ready |=> diff_valid && $stable(diff_word))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    obs_valid && !obs_ready |=> obs_valid && $stable(obs_word))
    else $error("waiting input word changed");

endmodule

bind epoch_difference_per_satellite edps_checker u_edps_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch difference regression bench
// Feeds satellite records to epoch_difference_per_satellite in epochs drawn
// from a slowly changing sky, predicts every difference word and checks the
// output stream field by field, under random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import edps_pkg::*;

  localparam int SAT_COUNT = 64;
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       obs_valid = 1'b0;
  logic       obs_ready;
  obs_word_t  obs_word = '0;
  logic       diff_valid;
  logic       diff_ready = 1'b0;
  diff_word_t diff_word;
  logic       cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_data = '0;

  epoch_difference_per_satellite dut (
    .clk        (clk),
    .rst        (rst),
    .obs_valid  (obs_valid),
    .obs_ready  (obs_ready),
    .obs_word   (obs_word),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff_word  (diff_word),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("epoch_difference_per_satellite regression: fail");
    $finish;
  end

  obs_word_t  pending_words[$];
  diff_word_t expected_diffs[$];
  bit         obs_busy = 1'b0;
  bit         steady = 1'b0;
  int         mismatch_count = 0;

  // Predicted block state: last record per satellite and the epoch masks.
  logic [MASK_W-1:0]  type_sel = '0;
  value_t             prior_values[SAT_COUNT][MAX_TYPES];
  logic [ARC_W-1:0]   prior_arc[SAT_COUNT];
  logic [MASK_W-1:0]  prior_present[SAT_COUNT];
  logic [SAT_COUNT-1:0] seen_prev = '0;
  logic [SAT_COUNT-1:0] seen_now = '0;

  // Stimulus generator's view of the sky.
  logic [SAT_COUNT-1:0] sky;
  logic [ARC_W-1:0]     sky_arc[SAT_COUNT];
  value_t               sky_values[SAT_COUNT][MAX_TYPES];

  function automatic diff_word_t difference_record(obs_word_t w);
    value_t now_v[MAX_TYPES];
    value_t d[MAX_TYPES];
    diff_word_t r;
    longint signed delta;
    logic [SAT_ID_W-1:0] s;
    bit kept;
    now_v[TYPE_CODE_PREFIT]  = w.value_code_prefit;
    now_v[TYPE_PHASE_PREFIT] = w.value_phase_prefit;
    now_v[TYPE_WET_MAP]      = w.value_wet_map;
    now_v[TYPE_C1_PREFIT]    = w.value_c1_prefit;
    now_v[TYPE_P1_PREFIT]    = w.value_p1_prefit;
    now_v[TYPE_P2_PREFIT]    = w.value_p2_prefit;
    now_v[TYPE_L1_PREFIT]    = w.value_l1_prefit;
    now_v[TYPE_L2_PREFIT]    = w.value_l2_prefit;
    s = w.sat_id;
    kept = seen_prev[s] && (prior_arc[s] == w.arc_number) &&
           ((type_sel & w.present_mask & prior_present[s]) == type_sel);
    for (int t = 0; t < MAX_TYPES; t++) begin
      d[t] = '0;
      if (kept && type_sel[t]) begin
        delta = longint'(now_v[t]) - longint'(prior_values[s][t]);
        if (delta > longint'(VALUE_MAX)) delta = longint'(VALUE_MAX);
        else if (delta < longint'(VALUE_MIN)) delta = longint'(VALUE_MIN);
        d[t] = delta[VALUE_WIDTH-1:0];
      end
    end
    prior_values[s] = now_v;
    prior_arc[s] = w.arc_number;
    prior_present[s] = w.present_mask;
    seen_now[s] = 1'b1;
    if (w.epoch_end) begin
      seen_prev = seen_now;
      seen_now = '0;
    end
    r.out_sat_id        = s;
    r.keep              = kept;
    r.diff_code_prefit  = d[TYPE_CODE_PREFIT];
    r.diff_phase_prefit = d[TYPE_PHASE_PREFIT];
    r.diff_wet_map      = d[TYPE_WET_MAP];
    r.diff_c1_prefit    = d[TYPE_C1_PREFIT];
    r.diff_p1_prefit    = d[TYPE_P1_PREFIT];
    r.diff_p2_prefit    = d[TYPE_P2_PREFIT];
    r.diff_l1_prefit    = d[TYPE_L1_PREFIT];
    r.diff_l2_prefit    = d[TYPE_L2_PREFIT];
    r.out_epoch_end     = w.epoch_end;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Prediction on acceptance, checking on delivery.
  always @(posedge clk) begin
    diff_word_t want;
    if (!rst && obs_valid && obs_ready) begin
      expected_diffs.push_back(difference_record(obs_word));
      obs_busy = 1'b0;
    end
    if (!rst && diff_valid && diff_ready) begin
      if (expected_diffs.size() == 0) begin
        $error("unexpected difference word for satellite %0d", diff_word.out_sat_id);
        mismatch_count++;
      end else begin
        want = expected_diffs.pop_front();
        check_field("out_sat_id", want.out_sat_id, diff_word.out_sat_id);
        check_field("keep", want.keep, diff_word.keep);
        check_field("diff_code_prefit", want.diff_code_prefit, diff_word.diff_code_prefit);
        check_field("diff_phase_prefit", want.diff_phase_prefit, diff_word.diff_phase_prefit);
        check_field("diff_wet_map", want.diff_wet_map, diff_word.diff_wet_map);
        check_field("diff_c1_prefit", want.diff_c1_prefit, diff_word.diff_c1_prefit);
        check_field("diff_p1_prefit", want.diff_p1_prefit, diff_word.diff_p1_prefit);
        check_field("diff_p2_prefit", want.diff_p2_prefit, diff_word.diff_p2_prefit);
        check_field("diff_l1_prefit", want.diff_l1_prefit, diff_word.diff_l1_prefit);
        check_field("diff_l2_prefit", want.diff_l2_prefit, diff_word.diff_l2_prefit);
        check_field("out_epoch_end", want.out_epoch_end, diff_word.out_epoch_end);
      end
    end
  end

  // A word stays on the bus until the posedge block sees it accepted.
  always @(negedge clk) begin
    if (!obs_busy) begin
      if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
        obs_word <= pending_words.pop_front();
        obs_valid <= 1'b1;
        obs_busy = 1'b1;
      end else begin
        obs_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    diff_ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  task automatic queue_record(logic [SAT_ID_W-1:0] s, logic [ARC_W-1:0] arc,
                              logic [MASK_W-1:0] pres, value_t v[MAX_TYPES], bit last);
    obs_word_t w;
    w.sat_id             = s;
    w.arc_number         = arc;
    w.present_mask       = pres;
    w.value_code_prefit  = v[TYPE_CODE_PREFIT];
    w.value_phase_prefit = v[TYPE_PHASE_PREFIT];
    w.value_wet_map      = v[TYPE_WET_MAP];
    w.value_c1_prefit    = v[TYPE_C1_PREFIT];
    w.value_p1_prefit    = v[TYPE_P1_PREFIT];
    w.value_p2_prefit    = v[TYPE_P2_PREFIT];
    w.value_l1_prefit    = v[TYPE_L1_PREFIT];
    w.value_l2_prefit    = v[TYPE_L2_PREFIT];
    w.epoch_end          = last;
    pending_words.push_back(w);
  endtask

  // Mostly a small step from the last value, sometimes a jump or an extreme.
  function automatic value_t next_value(value_t prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return prev + value_t'($urandom_range(0, 1048576)) - value_t'(524288);
    if (pick < 85) return value_t'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_epoch(inout int count);
    int members[$];
    int s;
    int pick;
    logic [MASK_W-1:0] pres;
    value_t v[MAX_TYPES];
    if ($urandom_range(0, 99) < 30) begin
      s = $urandom_range(0, SAT_COUNT - 1);
      sky[s] = ~sky[s];
    end
    for (int i = 0; i < SAT_COUNT; i++)
      if (sky[i] && $urandom_range(0, 99) < 90) members.push_back(i);
    if (members.size() == 0 || $urandom_range(0, 99) < 8)
      members.push_back($urandom_range(0, SAT_COUNT - 1));
    if ($urandom_range(0, 99) < 6)
      members.push_back(members[$urandom_range(0, members.size() - 1)]);
    foreach (members[i]) begin
      s = members[i];
      if ($urandom_range(0, 99) < 8) sky_arc[s] = $urandom_range(0, 65535);
      pick = $urandom_range(0, 99);
      if (pick < 75) pres = 8'hFF;
      else if (pick < 85) pres = ~(8'h01 << $urandom_range(0, 7));
      else pres = 8'($urandom);
      for (int t = 0; t < MAX_TYPES; t++) sky_values[s][t] = next_value(sky_values[s][t]);
      v = sky_values[s];
      // Now and then the epoch mark is dropped so two epochs run together.
      queue_record(s, sky_arc[s], pres, v,
                   (i == members.size() - 1) && ($urandom_range(0, 99) >= 3));
      count++;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || obs_busy || expected_diffs.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_type_mask(logic [MASK_W-1:0] m);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    type_sel = m;
  endtask

  initial begin
    value_t v[MAX_TYPES];
    logic [MASK_W-1:0] masks[8];
    int count;
    sky = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    for (int s = 0; s < SAT_COUNT; s++) begin
      sky_arc[s] = $urandom_range(0, 65535);
      for (int t = 0; t < MAX_TYPES; t++) sky_values[s][t] = value_t'({$urandom, $urandom});
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_type_mask(8'hFF);
    // First epoch: nothing seen before, so every record is rejected.
    v = '{default: VALUE_MAX}; queue_record(0, 100, 8'hFF, v, 1'b0);
    v = '{default: VALUE_MIN}; queue_record(63, 16'hFFFF, 8'hFF, v, 1'b0);
    v = '{default: 12345};     queue_record(5, 0, 8'h0F, v, 1'b1);
    // Saturation both ways, an arc change and repeats within the epoch.
    v = '{default: VALUE_MIN}; queue_record(0, 100, 8'hFF, v, 1'b0);
    v = '{default: VALUE_MAX}; queue_record(63, 16'hFFFF, 8'hFF, v, 1'b0);
    v = '{default: 12345};     queue_record(5, 1, 8'hFF, v, 1'b0);
    v = '{default: 0};         queue_record(0, 100, 8'hFF, v, 1'b0);
    v = '{default: -1};        queue_record(5, 1, 8'hFF, v, 1'b1);
    // A missing selected type, an ordinary difference and a new satellite.
    v = '{default: 7};         queue_record(5, 1, 8'hFE, v, 1'b0);
    v = '{default: 1000};      queue_record(63, 16'hFFFF, 8'hFF, v, 1'b0);
    v = '{default: 0};         queue_record(7, 3, 8'hFF, v, 1'b1);

    // Empty selection keeps on the seen and arc checks alone, with zero differences.
    set_type_mask(8'h00);
    v = '{default: 5};         queue_record(63, 16'hFFFF, 8'h00, v, 1'b0);
    v = '{default: 5};         queue_record(5, 1, 8'h00, v, 1'b0);
    v = '{default: 5};         queue_record(7, 4, 8'h00, v, 1'b1);

    masks = '{8'h00, 8'hFF, 8'($urandom), 8'h01, 8'h80, 8'h5A, 8'($urandom), 8'hFF};
    for (int p = 0; p < 8; p++) begin
      set_type_mask(masks[p]);
      @(posedge clk);
      steady = (p == 3);
      count = 0;
      while (count < 156) queue_epoch(count);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("epoch_difference_per_satellite regression: pass");
    end else begin
      $display("epoch_difference_per_satellite regression: fail");
    end
    $finish;
  end

endmodule
